FILE: sv/glq_pkg.sv
// Shared codes and types for the glyph quad layout block.
package glq_pkg;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] HIGH_CODE_BIT = 8'h80;

  localparam int LINE_DIST_W = 10;
  localparam int SPACING_W = 8;
  localparam int OFFSET_W = 8;
  localparam int CODE_W = 8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_LINE_DIST = 1'b0;
  localparam logic REG_CHAR_SPACING = 1'b1;

endpackage

FILE: sv/glyph_quad_layout_core.sv
// Top level of the glyph quad layout block: glyph loading, pen tracking and quad output.
//
// Input words arrive on item_valid/item_ready. A load word writes one glyph table
// entry; a draw word places one character at the pen and moves the pen. Each
// drawn non-special glyph with a nonzero width leaves four corner words on
// vert_valid/vert_ready, top-left first, with last_of_quad set on the fourth.
// An accepted word is held in one work register while its glyph entry is read
// from the table memory; corners then leave through an output register, so the
// first corner of a character passes through the work register and then the
// output register. A drawn quad holds the work register until its fourth corner
// enters the single output register. Load words, skipped characters and special
// glyphs never hold the work register back, so such words are taken every cycle.
// The next word is taken in the cycle the current one finishes.
// When the receiver stalls, the corner holds in the output register and the
// work register waits; item_ready falls once the work register cannot retire.
// Reset clears the glyph table valid bits, the pen, the line start and both
// configuration registers; item_ready is high after it. Configuration must be
// written over the APB port only while the block is idle; the block does not enforce it.
module glyph_quad_layout_core #(
  parameter int GLYPH_COUNT = 128,
  parameter int TEXEL_BITS = 11,
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [glq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [glq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [glq_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           kind,
  input  logic [glq_pkg::CODE_W-1:0]     char_code,
  input  logic                           first_of_string,
  input  logic signed [COORD_BITS-1:0]   start_x,
  input  logic signed [COORD_BITS-1:0]   start_y,
  input  logic [TEXEL_BITS-1:0]          glyph_left,
  input  logic [TEXEL_BITS-1:0]          glyph_right,
  input  logic [TEXEL_BITS-1:0]          glyph_top,
  input  logic [TEXEL_BITS-1:0]          glyph_bottom,
  input  logic signed [glq_pkg::OFFSET_W-1:0] glyph_x_offset,
  input  logic signed [glq_pkg::OFFSET_W-1:0] glyph_y_offset,
  input  logic                           glyph_special,
  output logic                           vert_valid,
  input  logic                           vert_ready,
  output logic signed [COORD_BITS-1:0]   vertex_x,
  output logic signed [COORD_BITS-1:0]   vertex_y,
  output logic [TEXEL_BITS-1:0]          tex_u,
  output logic [TEXEL_BITS-1:0]          tex_v,
  output logic [1:0]                     corner,
  output logic                           last_of_quad
);

  import glq_pkg::*;

  localparam int AW = $clog2(GLYPH_COUNT);
  localparam int ENT_W = 4 * TEXEL_BITS + 2 * OFFSET_W + 1;
  localparam logic [CODE_W:0] GCOUNT = (CODE_W + 1)'(GLYPH_COUNT);

  // Configuration registers.
  logic [LINE_DIST_W-1:0] line_distance;
  logic [SPACING_W-1:0]   char_spacing;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_distance <= '0;
      char_spacing <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LINE_DIST: line_distance <= pwdata[LINE_DIST_W-1:0];
        REG_CHAR_SPACING: char_spacing <= pwdata[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LINE_DIST: prdata = {{(APB_DATA_W-LINE_DIST_W){1'b0}}, line_distance};
      REG_CHAR_SPACING: prdata = {{(APB_DATA_W-SPACING_W){1'b0}}, char_spacing};
      default: prdata = '0;
    endcase
  end

  // Input decode and glyph table.
  logic             item_acc;
  logic             in_range;
  logic [AW-1:0]    tbl_idx;
  logic [ENT_W-1:0] wr_entry;
  logic [ENT_W-1:0] ent;

  assign item_acc = item_valid & item_ready;
  assign in_range = ({1'b0, char_code} < GCOUNT) && ((char_code & HIGH_CODE_BIT) == '0);
  assign tbl_idx = AW'(char_code);
  assign wr_entry = {glyph_left, glyph_right, glyph_top, glyph_bottom,
                     glyph_x_offset, glyph_y_offset, glyph_special};

  glq_glyph_table #(
    .DEPTH (GLYPH_COUNT),
    .DATA_W(ENT_W)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (item_acc && kind == KIND_LOAD && in_range),
    .wr_addr(tbl_idx),
    .wr_data(wr_entry),
    .rd_en  (item_acc && kind == KIND_DRAW && in_range),
    .rd_addr(tbl_idx),
    .rd_data(ent)
  );

  // Work register.
  logic                  b_valid;
  logic                  b_hit;
  logic                  b_first;
  logic                  b_newline;
  logic [COORD_BITS-1:0] b_start_x;
  logic [COORD_BITS-1:0] b_start_y;
  corner_t               b_corner;

  always_ff @(posedge clk) begin
    if (item_acc) begin
      b_hit <= (kind == KIND_DRAW) && in_range;
      b_first <= (kind == KIND_DRAW) && first_of_string;
      b_newline <= (char_code == NEWLINE_CODE);
      b_start_x <= start_x;
      b_start_y <= start_y;
    end
  end

  // Glyph entry fields.
  logic [TEXEL_BITS-1:0] e_left;
  logic [TEXEL_BITS-1:0] e_right;
  logic [TEXEL_BITS-1:0] e_top;
  logic [TEXEL_BITS-1:0] e_bottom;
  logic [OFFSET_W-1:0]   e_xoff;
  logic [OFFSET_W-1:0]   e_yoff;
  logic                  e_special;

  assign {e_left, e_right, e_top, e_bottom, e_xoff, e_yoff, e_special} = ent;

  // Pen state and layout arithmetic.
  logic [COORD_BITS-1:0] pen_x;
  logic [COORD_BITS-1:0] pen_y;
  logic [COORD_BITS-1:0] line_start_x;
  logic [COORD_BITS-1:0] px0;
  logic [COORD_BITS-1:0] py0;
  logic [COORD_BITS-1:0] lsx0;
  logic [COORD_BITS-1:0] px1;
  logic [COORD_BITS-1:0] py1;
  logic [COORD_BITS-1:0] pen_x_next;
  logic [COORD_BITS-1:0] sp_ext;
  logic [COORD_BITS-1:0] gw;
  logic [COORD_BITS-1:0] gh;
  logic [COORD_BITS-1:0] ox;
  logic [COORD_BITS-1:0] oy;
  logic                  b_emit;

  assign sp_ext = {{(COORD_BITS-SPACING_W){char_spacing[SPACING_W-1]}}, char_spacing};
  assign gw = COORD_BITS'(e_right) - COORD_BITS'(e_left);
  assign gh = COORD_BITS'(e_bottom) - COORD_BITS'(e_top);

  always_comb begin
    px0 = b_first ? b_start_x : pen_x;
    py0 = b_first ? b_start_y : pen_y;
    lsx0 = b_first ? b_start_x : line_start_x;
    px1 = px0;
    py1 = py0;
    b_emit = 1'b0;
    pen_x_next = px0;
    if (b_hit) begin
      if (b_newline) begin
        px1 = lsx0;
        py1 = py0 - COORD_BITS'(line_distance);
      end
      if (e_special) begin
        pen_x_next = px1 + COORD_BITS'(e_right) + sp_ext;
      end else if (e_right == e_left) begin
        pen_x_next = px1;
      end else begin
        b_emit = 1'b1;
        pen_x_next = px1 + gw + sp_ext;
      end
    end
  end

  assign ox = px1 + {{(COORD_BITS-OFFSET_W){e_xoff[OFFSET_W-1]}}, e_xoff};
  assign oy = py1 - {{(COORD_BITS-OFFSET_W){e_yoff[OFFSET_W-1]}}, e_yoff};

  // Corner sequencing and handshake.
  logic out_load;
  logic b_done;

  assign out_load = b_valid & b_emit & (~vert_valid | vert_ready);
  assign b_done = b_valid & (~b_emit | (out_load & (b_corner == CORNER_BL)));
  assign item_ready = ~b_valid | b_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_corner <= CORNER_TL;
      vert_valid <= 1'b0;
      pen_x <= '0;
      pen_y <= '0;
      line_start_x <= '0;
    end else begin
      if (item_acc) begin
        b_valid <= 1'b1;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (out_load) begin
        b_corner <= (b_corner == CORNER_BL) ? CORNER_TL : corner_t'(b_corner + 2'd1);
        vert_valid <= 1'b1;
      end else if (vert_ready) begin
        vert_valid <= 1'b0;
      end
      if (b_done) begin
        pen_x <= pen_x_next;
        pen_y <= py1;
        line_start_x <= lsx0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      corner <= b_corner;
      last_of_quad <= (b_corner == CORNER_BL);
      case (b_corner)
        CORNER_TL: begin
          vertex_x <= ox;
          vertex_y <= oy + gh;
          tex_u <= e_left;
          tex_v <= e_top;
        end
        CORNER_TR: begin
          vertex_x <= ox + gw;
          vertex_y <= oy + gh;
          tex_u <= e_right;
          tex_v <= e_top;
        end
        CORNER_BR: begin
          vertex_x <= ox + gw;
          vertex_y <= oy;
          tex_u <= e_right;
          tex_v <= e_bottom;
        end
        default: begin
          vertex_x <= ox;
          vertex_y <= oy;
          tex_u <= e_left;
          tex_v <= e_bottom;
        end
      endcase
    end
  end

  // The corner counter only leaves top-left while a quad is being emitted.
  a_corner_in_quad: assert property (@(posedge clk) disable iff (rst)
    b_corner != CORNER_TL |-> b_valid && b_emit)
    else $error("corner counter active without a quad in work");

  // A word that emits nothing never holds off the input.
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_emit |-> item_ready)
    else $error("non-emitting word stalled the input");

  // A quad retires only together with its fourth corner.
  a_retire_last: assert property (@(posedge clk) disable iff (rst)
    b_done && b_emit |=> vert_valid && last_of_quad)
    else $error("quad retired without its last corner");

endmodule

FILE: sv/glq_glyph_table.sv
// Glyph table memory with per-entry valid bits that reset clears.
module glq_glyph_table #(
  parameter int DEPTH = 128,
  parameter int DATA_W = 61
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (rd_en) begin
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule
